// File: rtl/tlt_pkg.sv
// Shared constants, token kinds and types of the tokenizer.
package tlt_pkg;

  localparam int KEYWORD_CHARS = 5;
  localparam int MAX_TOKENS    = 4;
  localparam int TOK_IW        = $clog2(MAX_TOKENS);
  localparam int GROUP_CW      = $clog2(MAX_TOKENS + 1);
  localparam int QUEUE_DEPTH   = 16;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W         = QUEUE_AW + 1;
  localparam int APB_ADDR_W    = 3;

  typedef logic [5:0]            kind_t;
  typedef logic [GROUP_CW-1:0]   group_cnt_t;
  typedef logic [QUEUE_AW-1:0]   q_ptr_t;
  typedef logic [CNT_W-1:0]      q_count_t;
  typedef logic [APB_ADDR_W-3:0] reg_sel_t;

  localparam reg_sel_t REG_START_LINE = '0;

  localparam kind_t K_IDENT   = 6'd0;
  localparam kind_t K_INT     = 6'd1;
  localparam kind_t K_TRUE    = 6'd2;
  localparam kind_t K_FALSE   = 6'd3;
  localparam kind_t K_EX      = 6'd4;
  localparam kind_t K_AX      = 6'd5;
  localparam kind_t K_EF      = 6'd6;
  localparam kind_t K_AF      = 6'd7;
  localparam kind_t K_EG      = 6'd8;
  localparam kind_t K_AG      = 6'd9;
  localparam kind_t K_E       = 6'd10;
  localparam kind_t K_A       = 6'd11;
  localparam kind_t K_U       = 6'd12;
  localparam kind_t K_R       = 6'd13;
  localparam kind_t K_BANG    = 6'd14;
  localparam kind_t K_AMP     = 6'd15;
  localparam kind_t K_BAR     = 6'd16;
  localparam kind_t K_ARROW   = 6'd17;
  localparam kind_t K_DARROW  = 6'd18;
  localparam kind_t K_PLUS    = 6'd19;
  localparam kind_t K_MINUS   = 6'd20;
  localparam kind_t K_STAR    = 6'd21;
  localparam kind_t K_LESSEQ  = 6'd22;
  localparam kind_t K_LESS    = 6'd23;
  localparam kind_t K_GREQ    = 6'd24;
  localparam kind_t K_GREATER = 6'd25;
  localparam kind_t K_EQ      = 6'd26;
  localparam kind_t K_LPAREN  = 6'd27;
  localparam kind_t K_RPAREN  = 6'd28;
  localparam kind_t K_LBRACK  = 6'd29;
  localparam kind_t K_RBRACK  = 6'd30;
  localparam kind_t K_LBRACE  = 6'd31;
  localparam kind_t K_RBRACE  = 6'd32;
  localparam kind_t K_COMMA   = 6'd33;
  localparam kind_t K_INF     = 6'd34;
  localparam kind_t K_EOF     = 6'd35;
  localparam kind_t K_ERROR   = 6'd36;

  typedef enum logic [3:0] {
    M_IDLE,
    M_COMMENT,
    M_IDENT,
    M_INT,
    M_LT,
    M_LTMINUS,
    M_GT,
    M_MINUS,
    M_ERROR
  } scan_mode_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [7:0]  length;
  } token_t;

  typedef struct packed {
    logic   last;
    token_t tok;
  } entry_t;

  // Tokens caused by one character, in order, slot 0 first.
  typedef struct packed {
    group_cnt_t                count;
    token_t [MAX_TOKENS-1:0]   toks;
  } token_group_t;

endpackage

// File: rtl/tlt_if.sv
// Valid/ready channel interfaces for characters in and tokens out.
interface tlt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_final;
  logic       end_only;

  modport source (output valid, char_code, is_final, end_only, input ready);
  modport sink (input valid, char_code, is_final, end_only, output ready);
endinterface

interface tlt_token_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [15:0] token_line;
  logic [15:0] token_column;
  logic [7:0]  token_length;
  logic        last_of_run;

  modport source (output valid, token_kind, token_line, token_column, token_length,
                  last_of_run, input ready);
  modport sink (input valid, token_kind, token_line, token_column, token_length,
                last_of_run, output ready);
endinterface

// File: rtl/temporal_logic_tokenizer.sv
// Temporal-logic formula tokenizer: one character in per cycle while ready; tokens out by a queue.
//
// The block takes one source byte per word on the chars channel and returns token words
// (kind, start line, start column, length, last-of-run flag) on the tokens channel. It takes
// a character every cycle: each accepted character is held in the input register, then the
// scanner decides it in one pass and writes the zero to four tokens it causes into a 16-word
// token queue. The queue hands out one token word per cycle while the tokens port is ready,
// so the sustained rate is one character per cycle while characters average at most one
// token each; beyond that the tokens port sets the pace at one token per cycle. The chars
// channel is ready while the queue fill, plus four for a character still in the scanner,
// is at most twelve. Register map (APB, byte address): 0x0 start_line, 16 bits, reset 1; a
// written 0 is taken as 1. Write it only while the block is idle; it also applies to a
// string with no character consumed yet. There is no clearing pass after reset.
module temporal_logic_tokenizer (
  input  logic                           clk,
  input  logic                           rst,
  tlt_char_if.sink                       chars,
  tlt_token_if.source                    tokens,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tlt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import tlt_pkg::*;

  // Room needed: a group still in the scanner plus one more behind it.
  localparam logic [CNT_W:0] GROUP_SLOTS = (CNT_W + 1)'(MAX_TOKENS);
  localparam logic [CNT_W:0] ROOM_LIMIT  = (CNT_W + 1)'(QUEUE_DEPTH - MAX_TOKENS);

  logic [15:0]    start_line;
  logic           busy;
  token_group_t   group;
  q_count_t       q_count;
  logic [CNT_W:0] demand;
  logic           take_ok;

  // Hold the start line; answer reads and writes with no wait states.
  tlt_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .start_line (start_line)
  );

  // Accept a character only when the queue can still absorb a full group from the
  // character now in the scanner and a full group from the new one.
  assign demand  = {1'b0, q_count} + (busy ? GROUP_SLOTS : '0);
  assign take_ok = (demand <= ROOM_LIMIT);

  // Register the character, scan it, advance line/column and word state.
  tlt_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .take_ok    (take_ok),
    .start_line (start_line),
    .busy       (busy),
    .group      (group)
  );

  // Queue the tokens and drain them one word per cycle while the tokens port is ready.
  tlt_tok_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .group  (group),
    .count  (q_count),
    .tokens (tokens)
  );

endmodule

// File: rtl/tlt_cfg.sv
// APB register block holding the start line number.
module tlt_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [15:0]                   start_line
);
  import tlt_pkg::*;

  reg_sel_t sel;
  logic     wr;

  assign sel    = paddr[APB_ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && (sel == REG_START_LINE);

  // Line zero is taken as line one.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_line <= 16'd1;
    end else if (wr) begin
      start_line <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
    end
  end

  always_comb begin
    prdata = (sel == REG_START_LINE) ? {16'd0, start_line} : 32'd0;
  end

endmodule

// File: rtl/tlt_scan.sv
// Input register and single-pass scanner: one character in, up to four tokens out.
module tlt_scan (
  input  logic                  clk,
  input  logic                  rst,
  tlt_char_if.sink              chars,
  input  logic                  take_ok,
  input  logic [15:0]           start_line,
  output logic                  busy,
  output tlt_pkg::token_group_t group
);
  import tlt_pkg::*;

  localparam int NUM_CAND = 6;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef logic [KEYWORD_CHARS-1:0][7:0] prefix_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } single_t;

  typedef struct packed {
    logic   v0;
    logic   v1;
    token_t t0;
    token_t t1;
  } flush_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic token_t make_tok(input kind_t k, input logic [15:0] l,
                                      input logic [15:0] c, input logic [7:0] n);
    token_t t;
    t.kind   = k;
    t.line   = l;
    t.column = c;
    t.length = n;
    return t;
  endfunction

  function automatic single_t single_kind(input logic [7:0] c);
    single_t s;
    s.hit = 1'b1;
    unique case (c)
      "!":     s.kind = K_BANG;
      "&":     s.kind = K_AMP;
      "|":     s.kind = K_BAR;
      "+":     s.kind = K_PLUS;
      "*":     s.kind = K_STAR;
      "=":     s.kind = K_EQ;
      "(":     s.kind = K_LPAREN;
      ")":     s.kind = K_RPAREN;
      "[":     s.kind = K_LBRACK;
      "]":     s.kind = K_RBRACK;
      "{":     s.kind = K_LBRACE;
      "}":     s.kind = K_RBRACE;
      ",":     s.kind = K_COMMA;
      default: begin
        s.hit  = 1'b0;
        s.kind = K_IDENT;
      end
    endcase
    return s;
  endfunction

  function automatic kind_t kw_kind(input prefix_t p, input logic [7:0] n);
    kind_t k;
    k = K_IDENT;
    if (n == 8'd1) begin
      unique case (p[0])
        "E":     k = K_E;
        "A":     k = K_A;
        "U":     k = K_U;
        "R":     k = K_R;
        default: k = K_IDENT;
      endcase
    end else if (n == 8'd2) begin
      unique case ({p[0], p[1]})
        "EX":    k = K_EX;
        "AX":    k = K_AX;
        "EF":    k = K_EF;
        "AF":    k = K_AF;
        "EG":    k = K_EG;
        "AG":    k = K_AG;
        default: k = K_IDENT;
      endcase
    end else if (n == 8'd3) begin
      if ({p[0], p[1], p[2]} == "inf" || {p[0], p[1], p[2]} == "INF" ||
          {p[0], p[1], p[2]} == "Inf") begin
        k = K_INF;
      end
    end else if (n == 8'd4) begin
      if ({p[0], p[1], p[2], p[3]} == "true") begin
        k = K_TRUE;
      end
    end else if (n == 8'd5) begin
      if ({p[0], p[1], p[2], p[3], p[4]} == "false") begin
        k = K_FALSE;
      end
    end
    return k;
  endfunction

  function automatic prefix_t word_add(input prefix_t p, input logic [7:0] n,
                                       input logic [7:0] c);
    prefix_t q;
    q = p;
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      if (n == 8'(i)) begin
        q[i] = c;
      end
    end
    return q;
  endfunction

  // Tokens owed by a pending mode when the next character does not extend it.
  function automatic flush_t flush(input scan_mode_t m, input prefix_t p,
                                   input logic [7:0] n, input logic [15:0] bl,
                                   input logic [15:0] bc);
    flush_t f;
    f.v0 = 1'b0;
    f.v1 = 1'b0;
    f.t0 = make_tok(K_LESS, bl, bc, 8'd1);
    f.t1 = make_tok(K_MINUS, bl, sat_inc(bc), 8'd1);
    unique case (m)
      M_IDENT: begin
        f.v0        = 1'b1;
        f.t0.kind   = kw_kind(p, n);
        f.t0.length = n;
      end
      M_INT: begin
        f.v0        = 1'b1;
        f.t0.kind   = K_INT;
        f.t0.length = n;
      end
      M_LT:      f.v0 = 1'b1;
      M_LTMINUS: begin
        f.v0 = 1'b1;
        f.v1 = 1'b1;
      end
      M_GT: begin
        f.v0      = 1'b1;
        f.t0.kind = K_GREATER;
      end
      M_MINUS: begin
        f.v0      = 1'b1;
        f.t0.kind = K_MINUS;
      end
      default:   f.v0 = 1'b0;
    endcase
    return f;
  endfunction

  // Input register
  logic       s_valid;
  logic [7:0] s_char;
  logic       s_fin;
  logic       s_end;

  // Scanner state
  scan_mode_t  mode, mode_next;
  logic        fresh, fresh_next;
  logic [15:0] cur_line, cur_line_next;
  logic [15:0] cur_col, cur_col_next;
  logic [15:0] begin_line, begin_line_next;
  logic [15:0] begin_col, begin_col_next;
  logic [7:0]  wlen, wlen_next;
  prefix_t     prefix, prefix_next;

  // State after the character, before any end of input
  scan_mode_t  mode_m;
  logic [15:0] line_m, col_m, bline_m, bcol_m;
  logic [7:0]  wlen_m;
  prefix_t     prefix_m;

  logic        cline_src;
  logic [15:0] cline;
  single_t     sk;
  logic        is_digit, is_alpha, is_word, is_nl, is_ws;
  logic        absorb, end_now;
  flush_t      fl_cur, fl_mid;
  logic        drop_v, own_v, eof_v;
  token_t      own_t, eof_t;
  logic [NUM_CAND-1:0]   cand_v;
  token_t [NUM_CAND-1:0] cand_t;
  group_cnt_t  n;

  assign chars.ready = take_ok;
  assign busy        = s_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= chars.valid && chars.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s_char <= chars.char_code;
      s_fin  <= chars.is_final;
      s_end  <= chars.end_only;
    end
  end

  // A fresh string has consumed nothing yet, so it follows the start line register.
  assign cline_src = fresh;
  assign cline     = cline_src ? start_line : cur_line;
  assign sk        = single_kind(s_char);
  assign is_digit  = (s_char >= "0") && (s_char <= "9");
  assign is_alpha  = ((s_char >= "a") && (s_char <= "z")) ||
                     ((s_char >= "A") && (s_char <= "Z"));
  assign is_word   = is_alpha || is_digit || (s_char == CH_UNDER);
  assign is_nl     = (s_char == CH_NL);
  assign is_ws     = (s_char == CH_SPACE) || (s_char == CH_TAB) || (s_char == CH_CR) ||
                     (s_char == CH_VT) || (s_char == CH_FF);
  assign end_now   = s_end || s_fin;
  assign fl_cur    = flush(mode, prefix, wlen, begin_line, begin_col);

  always_comb begin
    unique case (mode)
      M_ERROR:   absorb = 1'b1;
      M_COMMENT: absorb = !is_nl;
      M_IDENT:   absorb = is_word;
      M_INT:     absorb = is_digit;
      M_LT:      absorb = (s_char == CH_MINUS) || (s_char == CH_EQ);
      M_LTMINUS: absorb = (s_char == CH_GT);
      M_GT:      absorb = (s_char == CH_EQ);
      M_MINUS:   absorb = (s_char == CH_GT);
      default:   absorb = 1'b0;
    endcase
  end

  // Character step
  always_comb begin
    mode_m   = mode;
    line_m   = cline;
    col_m    = cur_col;
    bline_m  = begin_line;
    bcol_m   = begin_col;
    wlen_m   = wlen;
    prefix_m = prefix;
    drop_v   = 1'b0;
    own_v    = 1'b0;
    own_t    = make_tok(K_ERROR, cline, cur_col, 8'd1);
    if (!s_end) begin
      if (absorb) begin
        unique case (mode)
          M_ERROR:   mode_m = M_ERROR;
          M_COMMENT: col_m = sat_inc(cur_col);
          M_IDENT, M_INT: begin
            prefix_m = word_add(prefix, wlen, s_char);
            wlen_m   = (wlen == 8'hFF) ? wlen : wlen + 8'd1;
            col_m    = sat_inc(cur_col);
          end
          M_LT: begin
            col_m = sat_inc(cur_col);
            if (s_char == CH_MINUS) begin
              mode_m = M_LTMINUS;
            end else begin
              own_v  = 1'b1;
              own_t  = make_tok(K_LESSEQ, begin_line, begin_col, 8'd2);
              mode_m = M_IDLE;
            end
          end
          M_LTMINUS: begin
            col_m  = sat_inc(cur_col);
            own_v  = 1'b1;
            own_t  = make_tok(K_DARROW, begin_line, begin_col, 8'd3);
            mode_m = M_IDLE;
          end
          M_GT: begin
            col_m  = sat_inc(cur_col);
            own_v  = 1'b1;
            own_t  = make_tok(K_GREQ, begin_line, begin_col, 8'd2);
            mode_m = M_IDLE;
          end
          M_MINUS: begin
            col_m  = sat_inc(cur_col);
            own_v  = 1'b1;
            own_t  = make_tok(K_ARROW, begin_line, begin_col, 8'd2);
            mode_m = M_IDLE;
          end
          default:   mode_m = mode;
        endcase
      end else begin
        // Flush the pending token, then start over on this character.
        drop_v = 1'b1;
        mode_m = M_IDLE;
        col_m  = sat_inc(cur_col);
        priority if (is_nl) begin
          line_m = sat_inc(cline);
          col_m  = 16'd1;
        end else if (is_ws) begin
          col_m = sat_inc(cur_col);
        end else if (s_char == CH_HASH) begin
          mode_m = M_COMMENT;
        end else if (sk.hit) begin
          own_v = 1'b1;
          own_t = make_tok(sk.kind, cline, cur_col, 8'd1);
        end else if ((s_char == CH_LT) || (s_char == CH_GT) || (s_char == CH_MINUS)) begin
          mode_m  = (s_char == CH_LT) ? M_LT : ((s_char == CH_GT) ? M_GT : M_MINUS);
          bline_m = cline;
          bcol_m  = cur_col;
          wlen_m  = 8'd0;
        end else if (is_word) begin
          mode_m   = is_digit ? M_INT : M_IDENT;
          bline_m  = cline;
          bcol_m   = cur_col;
          wlen_m   = 8'd1;
          prefix_m = word_add(prefix, 8'd0, s_char);
        end else begin
          own_v  = 1'b1;
          own_t  = make_tok(K_ERROR, cline, cur_col, 8'd1);
          mode_m = M_ERROR;
        end
      end
    end
  end

  assign fl_mid = flush(mode_m, prefix_m, wlen_m, bline_m, bcol_m);
  assign eof_v  = end_now && (mode_m != M_ERROR);
  assign eof_t  = make_tok(K_EOF, line_m, col_m, 8'd0);

  // Next state: the character step, then re-arm at end of input.
  always_comb begin
    mode_next       = mode;
    fresh_next      = fresh;
    cur_line_next   = cur_line;
    cur_col_next    = cur_col;
    begin_line_next = begin_line;
    begin_col_next  = begin_col;
    wlen_next       = wlen;
    prefix_next     = prefix;
    if (s_valid) begin
      mode_next       = mode_m;
      fresh_next      = fresh && s_end;
      cur_line_next   = line_m;
      cur_col_next    = col_m;
      begin_line_next = bline_m;
      begin_col_next  = bcol_m;
      wlen_next       = wlen_m;
      prefix_next     = prefix_m;
      if (end_now) begin
        mode_next    = M_IDLE;
        fresh_next   = 1'b1;
        cur_col_next = 16'd1;
        wlen_next    = 8'd0;
      end
    end
  end

  // Outputs: pack the candidate tokens into consecutive slots.
  always_comb begin
    cand_v = {eof_v, end_now && fl_mid.v1, end_now && fl_mid.v0, own_v,
              drop_v && fl_cur.v1, drop_v && fl_cur.v0};
    cand_t = {eof_t, fl_mid.t1, fl_mid.t0, own_t, fl_cur.t1, fl_cur.t0};
    n = '0;
    group.toks = '0;
    for (int i = 0; i < NUM_CAND; i++) begin
      if (cand_v[i]) begin
        if (n < group_cnt_t'(MAX_TOKENS)) begin
          group.toks[n[TOK_IW-1:0]] = cand_t[i];
        end
        n = n + group_cnt_t'(1);
      end
    end
    group.count = s_valid ? n : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_IDLE;
      fresh   <= 1'b1;
      cur_col <= 16'd1;
      wlen    <= 8'd0;
    end else begin
      mode    <= mode_next;
      fresh   <= fresh_next;
      cur_col <= cur_col_next;
      wlen    <= wlen_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_line   <= cur_line_next;
    begin_line <= begin_line_next;
    begin_col  <= begin_col_next;
    prefix     <= prefix_next;
  end

`ifndef SYNTHESIS
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (s_valid && (mode == M_ERROR) && !end_now) |=> (mode == M_ERROR))
    else $error("scanner left error mode before end of input");

  a_end_rearms: assert property (@(posedge clk) disable iff (rst)
    (s_valid && end_now) |=> ((mode == M_IDLE) && fresh && (cur_col == 16'd1)))
    else $error("scanner not re-armed after end of input");
`endif

endmodule

// File: rtl/tlt_tok_fifo.sv
// Token queue: takes up to four tokens a cycle, hands out one word a cycle when ready.
module tlt_tok_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  tlt_pkg::token_group_t group,
  output tlt_pkg::q_count_t     count,
  tlt_token_if.source           tokens
);
  import tlt_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  q_ptr_t wptr;
  q_ptr_t rptr;
  logic   pop;
  entry_t head;

  assign pop                 = tokens.valid && tokens.ready;
  assign head                = mem[rptr];
  assign tokens.valid        = (count != '0);
  assign tokens.token_kind   = head.tok.kind;
  assign tokens.token_line   = head.tok.line;
  assign tokens.token_column = head.tok.column;
  assign tokens.token_length = head.tok.length;
  assign tokens.last_of_run  = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + q_ptr_t'(group.count);
      rptr  <= rptr + q_ptr_t'(pop);
      count <= count + q_count_t'(group.count) - q_count_t'(pop);
    end
  end

  // Mark the final token of each group.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (group_cnt_t'(i) < group.count) begin
        mem[wptr + q_ptr_t'(i)] <= '{last: (group_cnt_t'(i + 1) == group.count),
                                     tok: group.toks[i]};
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (int'(count) + int'(group.count) - int'(pop)) <= QUEUE_DEPTH)
    else $error("token queue overrun");

  a_eof_closes_run: assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && (tokens.token_kind == K_EOF)) |-> tokens.last_of_run)
    else $error("EOF token not last of its run");
`endif

endmodule

// File: tb/sv/temporal_logic_tokenizer_checker.sv
// Token checker: watches both channels and the register port, predicts token words, compares.
`timescale 1ns / 1ps
module temporal_logic_tokenizer_checker (
  input  logic                           clk,
  input  logic                           rst,
  tlt_char_if                            chars,
  tlt_token_if                           tokens,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tlt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  input  logic                           pready,
  output int                             fail_count,
  output int                             backlog
);
  import tlt_pkg::*;

  localparam logic [7:0] TAB      = 8'd9;
  localparam logic [7:0] NEWLINE  = 8'd10;
  localparam logic [7:0] VTAB     = 8'd11;
  localparam logic [7:0] FORMFEED = 8'd12;
  localparam logic [7:0] CR       = 8'd13;

  logic [15:0] first_line;
  scan_mode_t  mode;
  logic [7:0]  prefix [KEYWORD_CHARS];
  logic [7:0]  word_len;
  logic [15:0] tok_line, tok_col, line_no, col_no;
  bit          untouched;          // no character of the current string taken yet
  entry_t      char_tokens[$];     // tokens caused by the word being predicted
  entry_t      awaited_tokens[$];
  int          mismatches = 0;

  function automatic logic [15:0] bump(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // Single-character punctuation; K_ERROR when the byte is none of them.
  function automatic kind_t punct_kind(logic [7:0] c);
    case (c)
      "!": return K_BANG;
      "&": return K_AMP;
      "|": return K_BAR;
      "+": return K_PLUS;
      "*": return K_STAR;
      "=": return K_EQ;
      "(": return K_LPAREN;
      ")": return K_RPAREN;
      "[": return K_LBRACK;
      "]": return K_RBRACK;
      "{": return K_LBRACE;
      "}": return K_RBRACE;
      ",": return K_COMMA;
      default: return K_ERROR;
    endcase
  endfunction

  function automatic kind_t word_kind();
    kind_t k;
    k = K_IDENT;
    if (mode == M_INT) begin
      k = K_INT;
    end else begin
      case (word_len)
        8'd1: begin
          case (prefix[0])
            "E": k = K_E;
            "A": k = K_A;
            "U": k = K_U;
            "R": k = K_R;
            default: ;
          endcase
        end
        8'd2: begin
          case ({prefix[0], prefix[1]})
            "EX": k = K_EX;
            "AX": k = K_AX;
            "EF": k = K_EF;
            "AF": k = K_AF;
            "EG": k = K_EG;
            "AG": k = K_AG;
            default: ;
          endcase
        end
        8'd3: begin
          case ({prefix[0], prefix[1], prefix[2]})
            "inf", "INF", "Inf": k = K_INF;
            default: ;
          endcase
        end
        8'd4: if ({prefix[0], prefix[1], prefix[2], prefix[3]} == "true") k = K_TRUE;
        8'd5: begin
          if ({prefix[0], prefix[1], prefix[2], prefix[3], prefix[4]} == "false") k = K_FALSE;
        end
        default: ;
      endcase
    end
    return k;
  endfunction

  task automatic push_token(kind_t kind, logic [15:0] line, logic [15:0] column,
                            logic [7:0] length);
    entry_t e;
    e.last       = 1'b0;
    e.tok.kind   = kind;
    e.tok.line   = line;
    e.tok.column = column;
    e.tok.length = length;
    if (char_tokens.size() < MAX_TOKENS) char_tokens.insert(char_tokens.size(), e);
  endtask

  task automatic open_token(scan_mode_t m);
    mode     = m;
    tok_line = line_no;
    tok_col  = col_no;
    word_len = 8'd0;
  endtask

  task automatic extend_word(logic [7:0] c);
    if (word_len < KEYWORD_CHARS) prefix[word_len[2:0]] = c;
    if (word_len != 8'd255) word_len = word_len + 8'd1;
  endtask

  task automatic flush_pending();
    case (mode)
      M_IDENT, M_INT: push_token(word_kind(), tok_line, tok_col, word_len);
      M_LT: push_token(K_LESS, tok_line, tok_col, 8'd1);
      M_LTMINUS: begin
        push_token(K_LESS, tok_line, tok_col, 8'd1);
        push_token(K_MINUS, tok_line, bump(tok_col), 8'd1);
      end
      M_GT: push_token(K_GREATER, tok_line, tok_col, 8'd1);
      M_MINUS: push_token(K_MINUS, tok_line, tok_col, 8'd1);
      default: ;
    endcase
    if (mode != M_ERROR) mode = M_IDLE;
  endtask

  task automatic start_char(logic [7:0] c);
    kind_t k;
    k = punct_kind(c);
    if (c == NEWLINE) begin
      line_no = bump(line_no);
      col_no  = 16'd1;
      return;
    end
    if (c == " " || c == TAB || c == CR || c == VTAB || c == FORMFEED) begin
      col_no = bump(col_no);
      return;
    end
    if (c == "#") begin
      mode = M_COMMENT;
    end else if (k != K_ERROR) begin
      push_token(k, line_no, col_no, 8'd1);
    end else if (c == "<") begin
      open_token(M_LT);
    end else if (c == ">") begin
      open_token(M_GT);
    end else if (c == "-") begin
      open_token(M_MINUS);
    end else if (is_digit(c)) begin
      open_token(M_INT);
      extend_word(c);
    end else if (is_letter(c) || c == "_") begin
      open_token(M_IDENT);
      extend_word(c);
    end else begin
      push_token(K_ERROR, line_no, col_no, 8'd1);
      mode = M_ERROR;
    end
    col_no = bump(col_no);
  endtask

  task automatic take_char(logic [7:0] c);
    bit consumed;
    consumed = 1'b1;
    case (mode)
      M_ERROR: ;
      M_COMMENT: begin
        if (c == NEWLINE) begin
          mode = M_IDLE;
          start_char(c);
        end else begin
          col_no = bump(col_no);
        end
      end
      M_IDENT: begin
        if (is_digit(c) || is_letter(c) || c == "_") begin
          extend_word(c);
          col_no = bump(col_no);
        end else begin
          consumed = 1'b0;
        end
      end
      M_INT: begin
        if (is_digit(c)) begin
          extend_word(c);
          col_no = bump(col_no);
        end else begin
          consumed = 1'b0;
        end
      end
      M_LT: begin
        if (c == "-") begin
          mode   = M_LTMINUS;
          col_no = bump(col_no);
        end else if (c == "=") begin
          push_token(K_LESSEQ, tok_line, tok_col, 8'd2);
          mode   = M_IDLE;
          col_no = bump(col_no);
        end else begin
          consumed = 1'b0;
        end
      end
      M_LTMINUS: begin
        if (c == ">") begin
          push_token(K_DARROW, tok_line, tok_col, 8'd3);
          mode   = M_IDLE;
          col_no = bump(col_no);
        end else begin
          consumed = 1'b0;
        end
      end
      M_GT: begin
        if (c == "=") begin
          push_token(K_GREQ, tok_line, tok_col, 8'd2);
          mode   = M_IDLE;
          col_no = bump(col_no);
        end else begin
          consumed = 1'b0;
        end
      end
      M_MINUS: begin
        if (c == ">") begin
          push_token(K_ARROW, tok_line, tok_col, 8'd2);
          mode   = M_IDLE;
          col_no = bump(col_no);
        end else begin
          consumed = 1'b0;
        end
      end
      default: start_char(c);
    endcase
    if (!consumed) begin
      flush_pending();
      start_char(c);
    end
  endtask

  task automatic rearm();
    mode = M_IDLE;
    foreach (prefix[i]) prefix[i] = 8'd0;
    word_len  = 8'd0;
    tok_line  = first_line;
    tok_col   = 16'd1;
    line_no   = first_line;
    col_no    = 16'd1;
    untouched = 1'b1;
  endtask

  // An errored string ends silently; every other one closes with EOF.
  task automatic end_of_input();
    bit errored;
    errored = (mode == M_ERROR);
    flush_pending();
    if (!errored) push_token(K_EOF, line_no, col_no, 8'd0);
    rearm();
  endtask

  task automatic predict(logic [7:0] c, logic fin, logic eo);
    char_tokens.delete();
    if (eo) begin
      end_of_input();
    end else begin
      untouched = 1'b0;
      take_char(c);
      if (fin) end_of_input();
    end
    if (char_tokens.size() != 0) char_tokens[char_tokens.size() - 1].last = 1'b1;
    foreach (char_tokens[i]) awaited_tokens.insert(awaited_tokens.size(), char_tokens[i]);
  endtask

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_token();
    entry_t want;
    if (awaited_tokens.size() == 0) begin
      $error("token word with none expected: kind %0d, line %0d, column %0d",
             tokens.token_kind, tokens.token_line, tokens.token_column);
      mismatches++;
      return;
    end
    want = awaited_tokens.pop_front();
    compare_field("token_kind", 16'(want.tok.kind), 16'(tokens.token_kind));
    compare_field("token_line", want.tok.line, tokens.token_line);
    compare_field("token_column", want.tok.column, tokens.token_column);
    compare_field("token_length", 16'(want.tok.length), 16'(tokens.token_length));
    compare_field("last_of_run", 16'(want.last), 16'(tokens.last_of_run));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      first_line = 16'd1;
      rearm();
      awaited_tokens.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[tlt_pkg::APB_ADDR_W-1:2] == REG_START_LINE) begin
        first_line = (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
        if (untouched) begin
          line_no  = first_line;
          tok_line = first_line;
        end
      end
      if (chars.valid && chars.ready) predict(chars.char_code, chars.is_final, chars.end_only);
      if (tokens.valid && tokens.ready) check_token();
    end
    backlog    <= awaited_tokens.size();
    fail_count <= mismatches;
  end

endmodule

// File: tb/sv/temporal_logic_tokenizer_test.sv
// Testbench top of the tokenizer: clock, reset, character stimulus, register writes, verdict.
`timescale 1ns / 1ps
module temporal_logic_tokenizer_test;
  import tlt_pkg::*;

  localparam int RANDOM_WORDS = 240;   // random character words after the directed part
  localparam int QUIET_WORDS  = 50;    // closing stretch with no idling on either side
  localparam int LONG_HOLD    = 400;   // cycles the token side holds off under pressure

  localparam logic [7:0] TAB      = 8'd9;
  localparam logic [7:0] NEWLINE  = 8'd10;
  localparam logic [7:0] VTAB     = 8'd11;
  localparam logic [7:0] FORMFEED = 8'd12;
  localparam logic [7:0] CR       = 8'd13;

  // How a string is closed: flag on its last byte, a separate end-only word, or not yet.
  typedef enum int {END_ON_LAST, END_APART, END_LATER} ending_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata, prdata;
  logic                  pready;
  int                    fail_count, backlog;

  bit  sender_gaps  = 1'b1;  // random pauses between character words
  bit  quiet        = 1'b0;  // no idling anywhere
  bit  hold_request = 1'b0;  // ask the token side for one long hold-off
  int  words_sent   = 0;
  byte unsigned text[$];     // string being assembled for sending

  string lexemes [48] = '{
    "true", "false", "EX", "AX", "EF", "AF", "EG", "AG", "E", "A", "U", "R",
    "inf", "INF", "Inf", "!", "&", "|", "->", "<->", "+", "-", "*", "<=",
    "<", ">=", ">", "=", "(", ")", "[", "]", "{", "}", ",", "x1",
    "_t", "trues", "EXA", "fals", "0", "42", "65535", "#note", "<-", "p_Q9", "in", "Z"
  };

  tlt_char_if  chars_if();
  tlt_token_if tokens_if();

  temporal_logic_tokenizer dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .tokens  (tokens_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  temporal_logic_tokenizer_checker token_check (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars_if),
    .tokens     (tokens_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin : watchdog
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  // Token side: random ready bursts, one long hold-off on request, always ready when quiet.
  // A pending hold request cuts a ready stretch short so the hold starts right away.
  initial begin : token_receiver
    tokens_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        tokens_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else if (quiet) begin
        tokens_if.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        tokens_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        tokens_if.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) begin
          @(posedge clk);
          if (hold_request) break;
        end
      end
    end
  end

  // Offer one character word and return at the edge that accepts it. An optional gap
  // goes first, so valid stays high between back-to-back words.
  task automatic put_char(logic [7:0] c, logic fin, logic eo);
    if (sender_gaps && !quiet && $urandom_range(0, 5) == 0) begin
      chars_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    chars_if.valid     <= 1'b1;
    chars_if.char_code <= c;
    chars_if.is_final  <= fin;
    chars_if.end_only  <= eo;
    do @(posedge clk); while (!chars_if.ready);
    words_sent++;
  endtask

  // Append one byte to the string being assembled.
  task automatic put_byte(logic [7:0] b);
    text.insert(text.size(), b);
  endtask

  task automatic add(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // Send the assembled string and clear it; an empty string with END_APART is a bare end.
  task automatic send_text(ending_t ending);
    for (int i = 0; i < text.size(); i++)
      put_char(text[i], ending == END_ON_LAST && i == text.size() - 1, 1'b0);
    if (ending == END_APART) put_char(8'($urandom), 1'b0, 1'b1);
    text.delete();
  endtask

  // Drop valid and hold until every predicted token has come out, then allow for a
  // character still in flight that causes no token.
  task automatic settle();
    chars_if.valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_start_line(logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_START_LINE, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly lexemes with whitespace between them; one string in five is raw byte noise.
  task automatic build_string();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 8)) put_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 8)) begin
        add(lexemes[$urandom_range(0, 47)]);
        case ($urandom_range(0, 11))
          0: ;
          1: put_byte(TAB);
          2: put_byte(NEWLINE);
          3: put_byte(CR);
          4: put_byte(($urandom_range(0, 1) == 0) ? VTAB : FORMFEED);
          5: if ($urandom_range(0, 2) == 0) put_byte(8'($urandom));
          default: add(" ");
        endcase
      end
    end
  endtask

  function automatic logic [15:0] pick_start_line();
    case ($urandom_range(0, 9))
      0: return 16'hFFFF;
      1: return 16'd1;
      2: return 16'd0;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  initial begin : stimulus
    int goal;
    int strings;

    chars_if.valid     = 1'b0;
    chars_if.char_code = 8'd0;
    chars_if.is_final  = 1'b0;
    chars_if.end_only  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = 32'd0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, start line still at its reset value.
    // Two bare ends in a row: each is an empty string with EOF at line 1, column 1.
    send_text(END_APART);
    send_text(END_APART);
    // A pending "<-" at the end of input splits into '<' and '-'.
    add("a<-");
    send_text(END_ON_LAST);
    // "<-" before another byte splits as well; this one gives four tokens for one word.
    add("<-x");
    send_text(END_ON_LAST);
    // End of input inside a comment drops the comment, then EOF.
    add("1#c");
    send_text(END_APART);
    // A byte outside the language gives one error token; the rest is discarded, no EOF.
    add("x");
    put_byte(8'hFF);
    put_byte(8'h00);
    add("y");
    send_text(END_ON_LAST);
    add("<->-><=>=!");
    send_text(END_ON_LAST);
    settle();

    // A written zero reads as line 1; an error at the very first byte, then a bare end.
    write_start_line(16'd0);
    put_byte(8'h00);
    send_text(END_APART);
    settle();

    // Line number saturates at the top of its range.
    write_start_line(16'hFFFF);
    add("\nq\n");
    send_text(END_ON_LAST);
    settle();

    // Pressure: the token side holds off while punctuation floods in, so the token
    // queue fills and the character side stalls.
    write_start_line(pick_start_line());
    sender_gaps  = 1'b0;
    hold_request = 1'b1;
    repeat (30) add("()");
    send_text(END_ON_LAST);
    settle();
    sender_gaps = 1'b1;

    // Pause the sender in the middle of a string until it is fully drained, then change
    // the start line: it must not touch the string already under way.
    add("ab ");
    send_text(END_LATER);
    settle();
    write_start_line(pick_start_line());
    add("c");
    send_text(END_ON_LAST);

    // Random part: well-formed formulas with random content, some noise, new start
    // lines between groups of strings, and a closing stretch without any idling.
    goal    = words_sent + RANDOM_WORDS;
    strings = 0;
    while (words_sent < goal) begin
      if (words_sent >= goal - QUIET_WORDS) quiet = 1'b1;
      if (strings % 6 == 5 && !quiet) begin
        settle();
        write_start_line(pick_start_line());
        sender_gaps = ($urandom_range(0, 3) != 0);
      end
      build_string();
      send_text(($urandom_range(0, 4) == 0) ? END_APART : END_ON_LAST);
      strings++;
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
